### sv/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the quarter-round function of the ChaCha20 core.
// ----------------------------------------------------------------------------
package cc20_pkg;

   localparam int WordBits    = 32;
   localparam int StateWords  = 16;
   localparam int DoubleRounds = 10;
   localparam int Rounds      = 2 * DoubleRounds;
   localparam int RoundBits   = $clog2(Rounds);
   localparam int OffsetBits  = 6;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 64;

   localparam logic [31:0] ConstW0 = 32'h6170_7865;
   localparam logic [31:0] ConstW1 = 32'h3320_646e;
   localparam logic [31:0] ConstW2 = 32'h7962_2d32;
   localparam logic [31:0] ConstW3 = 32'h6b20_6574;

   localparam logic [RoundBits-1:0] LastRound = RoundBits'(Rounds - 1);

   typedef logic [WordBits-1:0] word_type;
   typedef word_type [StateWords-1:0] block_type;
   typedef word_type [3:0] quad_type;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_KEY_PART0     = 3'd0,
      CSR_KEY_PART1     = 3'd1,
      CSR_KEY_PART2     = 3'd2,
      CSR_KEY_PART3     = 3'd3,
      CSR_NONCE_LOW     = 3'd4,
      CSR_NONCE_HIGH    = 3'd5,
      CSR_START_COUNTER = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FINAL = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic round;
      logic diag;
      logic final_add;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic offset_zero;
   } status_type;

   function automatic word_type rotl(input word_type v, input int n);
      rotl = (v << n) | (v >> (WordBits - n));
   endfunction

   // a, b, c, d in elements 0..3
   function automatic quad_type quarter(input quad_type q);
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      a = q[0]; b = q[1]; c = q[2]; d = q[3];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      quarter = {d, c, b, a};
   endfunction

endpackage

### sv/cc20_controller.sv
// ----------------------------------------------------------------------------
// cc20_controller
// Sequencer for the ChaCha20 core: input hold, round count, output beat.
// ----------------------------------------------------------------------------
module cc20_controller
   import cc20_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type            state_ff, state_in;
   logic [RoundBits-1:0] round_ff, round_in;
   logic                 hold_valid_ff, hold_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = hold_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      cmd           = '0;
      cmd.capture   = req_valid && !hold_valid_ff;
      cmd.diag      = round_ff[0];
      case (state_ff)
         ST_IDLE: begin
            if (hold_valid_ff) begin
               if (status.offset_zero) begin
                  cmd.load = 1'b1;
                  round_in = '0;
                  state_in = ST_ROUND;
               end else if (out_free) begin
                  cmd.emit = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (round_ff == LastRound) begin
               state_in = ST_FINAL;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_FINAL: begin
            cmd.final_add = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      hold_valid_in = cmd.capture || (hold_valid_ff && !cmd.emit);
      rsp_valid_in  = cmd.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         round_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

### sv/cc20_datapath.sv
// ----------------------------------------------------------------------------
// cc20_datapath
// Configuration registers, working state, keystream block and byte XOR.
// ----------------------------------------------------------------------------
module cc20_datapath
   import cc20_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_write_data,
   input  logic [7:0]              req_data_in,
   input  logic                    req_last_byte,
   output logic [7:0]              rsp_data_out,
   output logic                    rsp_last_out,
   input  cmd_type                 cmd,
   output status_type              status
);

   logic [63:0]           key0_ff, key1_ff, key2_ff, key3_ff, nonce_low_ff;
   logic [31:0]           nonce_high_ff, start_counter_ff;
   logic [OffsetBits-1:0] offset_ff, offset_in, offset_inc;
   word_type              counter_ff, counter_in, load_counter;
   logic                  in_message_ff, in_message_in;
   block_type             work_ff, work_in, init_words, ks_ff;
   logic [7:0]            hold_data_ff, out_data_ff;
   logic                  hold_last_ff, out_last_ff;
   word_type              ks_word;
   logic [7:0]            ks_byte;

   assign status.offset_zero = (offset_ff == '0);
   assign rsp_data_out       = out_data_ff;
   assign rsp_last_out       = out_last_ff;

   assign load_counter = in_message_ff ? counter_ff : start_counter_ff;

   always_comb begin
      init_words[0]  = ConstW0;
      init_words[1]  = ConstW1;
      init_words[2]  = ConstW2;
      init_words[3]  = ConstW3;
      init_words[4]  = key0_ff[31:0];
      init_words[5]  = key0_ff[63:32];
      init_words[6]  = key1_ff[31:0];
      init_words[7]  = key1_ff[63:32];
      init_words[8]  = key2_ff[31:0];
      init_words[9]  = key2_ff[63:32];
      init_words[10] = key3_ff[31:0];
      init_words[11] = key3_ff[63:32];
      init_words[12] = cmd.load ? load_counter : counter_ff;
      init_words[13] = nonce_low_ff[31:0];
      init_words[14] = nonce_low_ff[63:32];
      init_words[15] = nonce_high_ff;
   end

   // column round or diagonal round, four quarter rounds side by side
   always_comb begin
      quad_type   q;
      quad_type   r;
      logic [3:0] ib;
      logic [3:0] ic;
      logic [3:0] id;
      work_in = work_ff;
      for (int i = 0; i < 4; i++) begin
         ib = cmd.diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
         ic = cmd.diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
         id = cmd.diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
         q  = {work_ff[id], work_ff[ic], work_ff[ib], work_ff[i]};
         r  = quarter(q);
         work_in[i]  = r[0];
         work_in[ib] = r[1];
         work_in[ic] = r[2];
         work_in[id] = r[3];
      end
   end

   assign ks_word    = ks_ff[offset_ff[5:2]];
   assign ks_byte    = ks_word[{offset_ff[1:0], 3'b000} +: 8];
   assign offset_inc = offset_ff + 1'b1;

   always_comb begin
      offset_in     = offset_ff;
      counter_in    = counter_ff;
      in_message_in = in_message_ff;
      if (cmd.load) begin
         counter_in    = load_counter;
         in_message_in = 1'b1;
      end
      if (cmd.emit) begin
         offset_in = offset_inc;
         if (offset_inc == '0) begin
            counter_in = counter_ff + 1'b1;
         end
         if (hold_last_ff) begin
            offset_in     = '0;
            in_message_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff          <= '0;
         key1_ff          <= '0;
         key2_ff          <= '0;
         key3_ff          <= '0;
         nonce_low_ff     <= '0;
         nonce_high_ff    <= '0;
         start_counter_ff <= 32'd1;
         offset_ff        <= '0;
         counter_ff       <= 32'd1;
         in_message_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_KEY_PART0:     key0_ff          <= csr_write_data;
               CSR_KEY_PART1:     key1_ff          <= csr_write_data;
               CSR_KEY_PART2:     key2_ff          <= csr_write_data;
               CSR_KEY_PART3:     key3_ff          <= csr_write_data;
               CSR_NONCE_LOW:     nonce_low_ff     <= csr_write_data;
               CSR_NONCE_HIGH:    nonce_high_ff    <= csr_write_data[31:0];
               CSR_START_COUNTER: start_counter_ff <= csr_write_data[31:0];
               default: begin
               end
            endcase
         end
         offset_ff     <= offset_in;
         counter_ff    <= counter_in;
         in_message_ff <= in_message_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_data_ff <= req_data_in;
         hold_last_ff <= req_last_byte;
      end
      if (cmd.load) begin
         work_ff <= init_words;
      end else if (cmd.round) begin
         work_ff <= work_in;
      end
      if (cmd.final_add) begin
         for (int i = 0; i < StateWords; i++) begin
            ks_ff[i] <= work_ff[i] + init_words[i];
         end
      end
      if (cmd.emit) begin
         out_data_ff <= hold_data_ff ^ ks_byte;
         out_last_ff <= hold_last_ff;
      end
   end

endmodule

### sv/chacha20_stream_cipher_core.sv
// Data path: an accepted byte is held in the input hold register, then XORed with
// its keystream byte into the output register; the first byte of a block waits
// for load, 20 rounds and the final add. A new byte is taken only once the held
// byte has been emitted, and the emit waits while the output is stalled.
// Reset: synchronous, active high; zeroes offset, message flag, key and nonce,
// sets counter and start counter to one; the keystream block is left unset.
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 byte stream cipher: controller and datapath.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core
   import cc20_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_in,
   input  logic                    req_last_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_data_out,
   output logic                    rsp_last_out,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_write_data
);

   cmd_type    cmd;
   status_type status;

   cc20_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cc20_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data_in      (req_data_in),
      .req_last_byte    (req_last_byte),
      .rsp_data_out     (rsp_data_out),
      .rsp_last_out     (rsp_last_out),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
